FILE: hw/rtl/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg
// types shared by the activity selection cell chain and its controller
// ----------------------------------------------------------------------------
package ias_pkg;

  // one incoming activity transaction
  typedef struct packed {
    logic [15:0] activity_id;
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic        last_item;
  } act_t;

  // one selected activity transaction
  typedef struct packed {
    logic [15:0] selected_id;
    logic [15:0] selected_start;
    logic [15:0] selected_finish;
    logic        last_result;
    logic        overflow;
  } res_t;

  // contents held by one cell
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] start;
    logic [15:0] finish;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;   // insert the new entry in finish order
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

FILE: hw/rtl/interval_activity_selection.sv
// ----------------------------------------------------------------------------
// interval_activity_selection
// greedy activity selection, earliest finish first, on a chain of sort cells
// ----------------------------------------------------------------------------
// Activities are loaded one per cycle (start high while busy is low) and are
// sorted on the fly into a row of MAX_ACTIVITIES cells by finish time; equal
// finishes keep arrival order. The transaction with last_item set closes the
// set: busy then rises and the chain drains one entry per cycle from its
// head through the greedy picker; busy falls once the chain is empty and
// the final selection is registered. Each selected activity appears on
// result_o for exactly one cycle with result_valid_o high; there is no
// backpressure, the receiver must take every result as it comes. The final
// selection of a set carries last_result, and every result of a set
// carries overflow if transactions were dropped because the set went
// beyond MAX_ACTIVITIES entries.
// ----------------------------------------------------------------------------
module interval_activity_selection
  import ias_pkg::*;
#(
  parameter int MAX_ACTIVITIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  act_t act_i,
  output res_t result_o,
  output logic result_valid_o
);

  localparam int CntW = $clog2(MAX_ACTIVITIES + 1);

  // controller state
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;      // entries held in the chain
  logic              ovf_q, ovf_d;          // drops seen in the current set
  logic              pend_vld_q, pend_vld_d; // a selection waits for output
  entry_t            pend_q, pend_d;        // last selected, not yet sent
  res_t              res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic      accept;
  cell_ctl_t ctl;
  entry_t    new_entry;

  // chain wiring
  entry_t cell_entry [MAX_ACTIVITIES];
  logic   cell_ins   [MAX_ACTIVITIES];

  assign accept    = start && (state_q == ST_LOAD);
  assign busy      = (state_q == ST_DRAIN);
  assign new_entry = '{id: act_i.activity_id, start: act_i.start_time,
                       finish: act_i.finish_time};

  // ------------------------------------------------------------ cell chain
  for (genvar g = 0; g < MAX_ACTIVITIES; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ins;
    logic   occ;

    if (g == 0) begin : g_head
      assign left_e   = new_entry;
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_e   = cell_entry[g-1];
      assign left_ins = cell_ins[g-1];
    end

    if (g == MAX_ACTIVITIES - 1) begin : g_tail
      // tail slot falls out of the occupied range on a drain shift
      assign right_e = cell_entry[g];
    end else begin : g_body
      assign right_e = cell_entry[g+1];
    end

    assign occ = (count_q > CntW'(g));

    ias_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ),
      .new_i      (new_entry),
      .left_i     (left_e),
      .left_ins_i (left_ins),
      .right_i    (right_e),
      .entry_o    (cell_entry[g]),
      .ins_o      (cell_ins[g])
    );
  end

  // ------------------------------------------------------------ controller
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    ctl        = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (count_q < CntW'(MAX_ACTIVITIES)) begin
            ctl.load = 1'b1;
            count_d  = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (act_i.last_item) begin
            state_d    = ST_DRAIN;
            pend_vld_d = 1'b0;
          end
        end
      end

      ST_DRAIN: begin
        if (count_q != '0) begin
          // greedy pick on the head of the sorted chain
          ctl.shift = 1'b1;
          count_d   = count_q - CntW'(1);
          if (!pend_vld_q || (cell_entry[0].start >= pend_q.finish)) begin
            if (pend_vld_q) begin
              res_vld_d = 1'b1;
              res_d     = '{selected_id: pend_q.id, selected_start: pend_q.start,
                            selected_finish: pend_q.finish, last_result: 1'b0,
                            overflow: ovf_q};
            end
            pend_d     = cell_entry[0];
            pend_vld_d = 1'b1;
          end
        end else begin
          // chain empty: the held selection is the final one
          res_vld_d  = 1'b1;
          res_d      = '{selected_id: pend_q.id, selected_start: pend_q.start,
                         selected_finish: pend_q.finish, last_result: 1'b1,
                         overflow: ovf_q};
          pend_vld_d = 1'b0;
          ovf_d      = 1'b0;
          state_d    = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

endmodule

FILE: hw/rtl/ias_cell.sv
// ----------------------------------------------------------------------------
// ias_cell
// one slot of the insertion-sort chain: compares, takes the new entry or
// its left neighbor on insert, takes its right neighbor on drain
// ----------------------------------------------------------------------------
module ias_cell
  import ias_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,       // slot holds an entry of the current set
  input  entry_t    new_i,
  input  entry_t    left_i,
  input  logic      left_ins_i,  // left neighbor also moves right
  input  entry_t    right_i,
  output entry_t    entry_o,
  output logic      ins_o        // new entry goes at or before this slot
);

  entry_t entry_q, entry_d;

  // strict compare keeps equal finishes in arrival order
  assign ins_o   = !occ_i || (entry_q.finish > new_i.finish);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load && ins_o) begin
      entry_d = left_ins_i ? left_i : new_i;
    end else if (ctl_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
